// ===== hdl/sorted_priority_queue_core_macros.svh =====
// Assertion macros used by the sorted priority queue RTL.
// No dependencies; included by sorted_priority_queue_core.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spq assertion failed");

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spq assertion failed");

`endif

// ===== hdl/spq_pkg.sv =====
// Package of the sorted priority queue: sizes, codes, entry and control types.
// No dependencies; imported by spq_cell and sorted_priority_queue_core.
`default_nettype none

package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [13:0] MIN_YEAR = 14'd23;
   localparam logic [3:0] MAX_MONTH = 4'd12;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP = 1'b1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_BAD_DATE = 2'd3;

   typedef struct packed {
      logic [15:0] tag;
      logic signed [15:0] prio;
      logic [4:0] day;
      logic [3:0] month;
      logic [13:0] year;
   } entry_type;

   typedef struct packed {
      logic ins;
      logic pop;
      entry_type entry;
   } ctl_type;

endpackage

`default_nettype wire

// ===== hdl/sorted_priority_queue_core.sv =====
// Top level of the sorted priority queue: command decode, cell row and result register.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_core_macros.svh.
//
//   Channel   Ports                         Handshake
//   request   req_*, start, busy            beat taken when start && !busy
//   response  rsp_*                         beat shown for one cycle with rsp_valid
//
// Every beat is finished without a wait: the cell row updates at the accepting edge
// and the result appears on the next cycle, so a new beat can follow at once.
// Busy stays low; the shift row of cells completes an insert or a pop at that edge.
// Reset clears the entry count and the result strobe; cell contents are left as is.
// The receiver cannot stall, so results never wait.
`default_nettype none

module sorted_priority_queue_core (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic req_command,
   input wire logic [15:0] req_entry_tag,
   input wire logic signed [15:0] req_entry_priority,
   input wire logic [4:0] req_entry_day,
   input wire logic [3:0] req_entry_month,
   input wire logic [13:0] req_entry_year,
   output logic rsp_valid,
   output logic [1:0] rsp_status,
   output logic [15:0] rsp_out_tag,
   output logic signed [15:0] rsp_out_priority,
   output logic [4:0] rsp_out_day,
   output logic [3:0] rsp_out_month,
   output logic [13:0] rsp_out_year,
   output logic [spq_pkg::CNT_W-1:0] rsp_entry_count
);
   import spq_pkg::*;
`include "sorted_priority_queue_core_macros.svh"

   logic accept;
   logic date_ok;
   logic ins_ok;
   logic pop_ok;
   entry_type new_entry;
   ctl_type ctl;
   entry_type cell_entry [QUEUE_DEPTH];
   logic cell_keeps [QUEUE_DEPTH];

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic rsp_valid_ff;
   logic [1:0] status_ff;
   logic [1:0] status_in;
   entry_type out_ff;
   entry_type out_in;

   assign busy = 1'b0;
   assign accept = start && !busy;

   assign new_entry.tag = req_entry_tag;
   assign new_entry.prio = req_entry_priority;
   assign new_entry.day = req_entry_day;
   assign new_entry.month = req_entry_month;
   assign new_entry.year = req_entry_year;

   assign date_ok = (req_entry_year >= MIN_YEAR) && (req_entry_month <= MAX_MONTH);
   assign ins_ok = accept && (req_command == CMD_INSERT) && date_ok
      && (count_ff < CNT_W'(QUEUE_DEPTH));
   assign pop_ok = accept && (req_command == CMD_POP) && (count_ff != '0);

   assign ctl.ins = ins_ok;
   assign ctl.pop = pop_ok;
   assign ctl.entry = new_entry;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      spq_cell u_cell (
         .clock(clock),
         .ctl(ctl),
         .occupied(CNT_W'(i) < count_ff),
         .upper_entry((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
         .upper_keeps((i == 0) ? 1'b1 : cell_keeps[(i == 0) ? 0 : i - 1]),
         .lower_entry((i == QUEUE_DEPTH - 1) ? cell_entry[i]
            : cell_entry[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
         .entry(cell_entry[i]),
         .keeps(cell_keeps[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      status_in = ST_OK;
      out_in = cell_entry[0];
      if (req_command == CMD_POP) begin
         if (count_ff == '0) begin
            status_in = ST_EMPTY;
            out_in = '0;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end else begin
         if (!date_ok) begin
            status_in = ST_BAD_DATE;
         end else if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
            status_in = ST_FULL;
         end else begin
            count_in = count_ff + 1'b1;
            if (!cell_keeps[0]) begin
               out_in = new_entry;
            end
         end
         if (count_in == '0) begin
            out_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         out_ff <= out_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_out_tag = out_ff.tag;
   assign rsp_out_priority = out_ff.prio;
   assign rsp_out_day = out_ff.day;
   assign rsp_out_month = out_ff.month;
   assign rsp_out_year = out_ff.year;
   assign rsp_entry_count = count_ff;

   `SPQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `SPQ_ASSERT_NEXT(a_beat_answered, clock, reset, accept, rsp_valid_ff)
   `SPQ_ASSERT_NEXT(a_no_spurious, clock, reset, !accept, !rsp_valid_ff)
   `SPQ_ASSERT_NEXT(a_insert_grows, clock, reset, ins_ok,
      count_ff == CNT_W'($past(count_ff) + 1'b1))
   `SPQ_ASSERT_NEXT(a_empty_pop, clock, reset, accept && (req_command == CMD_POP)
      && (count_ff == '0), (status_ff == ST_EMPTY) && (count_ff == '0))

endmodule

`default_nettype wire

// ===== hdl/spq_cell.sv =====
// One cell of the sorted queue row: holds one entry and trades with its neighbors.
// Depends on spq_pkg.
`default_nettype none

module spq_cell (
   input wire logic clock,
   input wire spq_pkg::ctl_type ctl,
   input wire logic occupied,
   input wire spq_pkg::entry_type upper_entry,
   input wire logic upper_keeps,
   input wire spq_pkg::entry_type lower_entry,
   output spq_pkg::entry_type entry,
   output logic keeps
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   assign keeps = occupied && ($signed(entry_ff.prio) >= $signed(ctl.entry.prio));
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins) begin
         if (keeps) begin
            entry_in = entry_ff;
         end else if (upper_keeps) begin
            entry_in = ctl.entry;
         end else begin
            entry_in = upper_entry;
         end
      end else if (ctl.pop) begin
         entry_in = lower_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire
